### hw/rtl/avb_pkg.sv
// shared types and constants for the envelope voice bank
`timescale 1ns / 1ps
package avb_pkg;

	localparam int LEVEL_W = 21;
	localparam int TIMER_W = 24;
	localparam int PRESS_W = 25;
	localparam int SEL_W = 4;
	localparam int CMD_W = 3;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	localparam logic [CMD_W-1:0] CMD_STEP = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PRESS_ALLOC = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PRESS_VOICE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SET_LEVEL = 3'd5;

	localparam logic [2:0] REG_ATTACK = 3'd0;
	localparam logic [2:0] REG_DECAY = 3'd1;
	localparam logic [2:0] REG_RELEASE = 3'd2;
	localparam logic [2:0] REG_PEAK = 3'd3;
	localparam logic [2:0] REG_SUSTAIN = 3'd4;
	localparam logic [2:0] REG_MASTER = 3'd5;
	localparam logic [2:0] REG_MAX_STEP = 3'd6;

	typedef struct packed {
		logic [TIMER_W-1:0] attack;
		logic [TIMER_W-1:0] decay;
		logic [TIMER_W-1:0] release_len;
		logic [LEVEL_W-1:0] peak;
		logic [LEVEL_W-1:0] sustain;
		logic [LEVEL_W-1:0] master;
		logic [LEVEL_W-1:0] max_step;
	} cfg_t;

	typedef enum logic [3:0] {
		DP_NOP, DP_LATCH, DP_SCAN, DP_EXEC, DP_TICK, DP_ENV_SET, DP_REL_SET,
		DP_IMUL, DP_IDIV, DP_IFIN, DP_GM, DP_LO, DP_HI, DP_SUM, DP_SLEW, DP_OUT
	} dp_op_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
		logic enabled;
		logic held;
	} dp_status_t;

endpackage

### hw/rtl/adsr_voice_bank.sv
// top level: register port, sequencer and datapath of the voice bank
//
//  channel  signals                              direction
//  in       in_valid in_ready command voice_sel voice_level   word in
//  out      out_valid out_ready voice_out level_out active    word out
//  cfg      psel penable pwrite paddr pwdata prdata pready    register access
//
// one word at a time; a step runs the 21-bit divider (one quotient bit per cycle) once
// with the voice held and twice after release
// press allocate first scans the voices for a free one, else the lowest release count
// reset clears flags, the sequencer and the registers to their defaults
// a result held on out waits for out_ready; the next word is taken meanwhile
`timescale 1ns / 1ps
module adsr_voice_bank #(
	parameter int VOICES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [avb_pkg::CMD_W-1:0]     command,
	input  logic [avb_pkg::SEL_W-1:0]     voice_sel,
	input  logic [avb_pkg::LEVEL_W-1:0]   voice_level,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [avb_pkg::SEL_W-1:0]     voice_out,
	output logic [avb_pkg::LEVEL_W-1:0]   level_out,
	output logic                          active,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [4:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	avb_pkg::cfg_t cfg_q;
	avb_pkg::dp_status_t status;
	avb_pkg::dp_op_t op;
	logic [2:0] reg_idx;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack <= 24'd3360;
			cfg_q.decay <= 24'd9600;
			cfg_q.release_len <= 24'd2400;
			cfg_q.peak <= 21'd1048576;
			cfg_q.sustain <= 21'd524288;
			cfg_q.master <= 21'd524288;
			cfg_q.max_step <= 21'd699;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				avb_pkg::REG_ATTACK: cfg_q.attack <= pwdata[23:0];
				avb_pkg::REG_DECAY: cfg_q.decay <= pwdata[23:0];
				avb_pkg::REG_RELEASE: cfg_q.release_len <= pwdata[23:0];
				avb_pkg::REG_PEAK: cfg_q.peak <= pwdata[20:0];
				avb_pkg::REG_SUSTAIN: cfg_q.sustain <= pwdata[20:0];
				avb_pkg::REG_MASTER: cfg_q.master <= pwdata[20:0];
				avb_pkg::REG_MAX_STEP: cfg_q.max_step <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			avb_pkg::REG_ATTACK: prdata = 32'(cfg_q.attack);
			avb_pkg::REG_DECAY: prdata = 32'(cfg_q.decay);
			avb_pkg::REG_RELEASE: prdata = 32'(cfg_q.release_len);
			avb_pkg::REG_PEAK: prdata = 32'(cfg_q.peak);
			avb_pkg::REG_SUSTAIN: prdata = 32'(cfg_q.sustain);
			avb_pkg::REG_MASTER: prdata = 32'(cfg_q.master);
			avb_pkg::REG_MAX_STEP: prdata = 32'(cfg_q.max_step);
			default: prdata = '0;
		endcase
	end

	avb_ctrl #(.VOICES(VOICES)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.voice_sel(voice_sel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.op(op)
	);

	avb_dp #(.VOICES(VOICES)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.op(op),
		.cfg(cfg_q),
		.command(command),
		.voice_sel(voice_sel),
		.voice_level(voice_level),
		.status(status),
		.voice_out(voice_out),
		.level_out(level_out),
		.active(active)
	);

endmodule

### hw/rtl/avb_dp.sv
// voice state, shared multiplier, divider and output word register
`timescale 1ns / 1ps
module avb_dp #(
	parameter int VOICES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  avb_pkg::dp_op_t               op,
	input  avb_pkg::cfg_t                 cfg,
	input  logic [avb_pkg::CMD_W-1:0]     command,
	input  logic [avb_pkg::SEL_W-1:0]     voice_sel,
	input  logic [avb_pkg::LEVEL_W-1:0]   voice_level,
	output avb_pkg::dp_status_t           status,
	output logic [avb_pkg::SEL_W-1:0]     voice_out,
	output logic [avb_pkg::LEVEL_W-1:0]   level_out,
	output logic                          active
);
	localparam int VIW = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int LW = avb_pkg::LEVEL_W;
	localparam int TW = avb_pkg::TIMER_W;
	localparam int PW = avb_pkg::PRESS_W;

	logic [VOICES-1:0] en_q, held_q;
	logic [PW-1:0] pc_q [VOICES];
	logic [TW-1:0] rc_q [VOICES];
	logic [LW-1:0] gain_q [VOICES];
	logic [LW-1:0] lvl_q [VOICES];

	logic [avb_pkg::CMD_W-1:0] cmd_q;
	logic [avb_pkg::SEL_W-1:0] sel_q;
	logic [LW-1:0] lvlin_q;
	logic [VIW-1:0] v_q, scan_q;
	logic [TW:0] best_q;
	logic [LW-1:0] ia_q, ib_q, env_q;
	logic [PW-1:0] it_q;
	logic [TW-1:0] il_q, rem_q;
	logic [LW-1:0] lowq_q;
	logic [4:0] dcnt_q;
	logic neg_q, zero_q;
	logic [2*LW-1:0] gm_q, hi_q;
	logic [3*LW-1:0] acc_q;

	logic [VIW-1:0] rd_idx;
	logic rd_en, rd_held;
	logic [PW-1:0] rd_pc;
	logic [TW-1:0] rd_rc;
	logic [LW-1:0] rd_gain, rd_lvl;
	logic [TW-1:0] tt, mag;
	logic [2*TW-1:0] mul_p;
	logic [TW-1:0] mul_a, mul_b;
	logic [TW:0] trial;
	logic ge, sel_bad;
	logic [LW+1:0] tgt_hi;
	logic [LW-1:0] tgt, lim, new_lvl;

	always_comb begin
		rd_idx = (op == avb_pkg::DP_SCAN) ? scan_q : v_q;
		rd_en = en_q[rd_idx];
		rd_held = held_q[rd_idx];
		rd_pc = pc_q[rd_idx];
		rd_rc = rc_q[rd_idx];
		rd_gain = gain_q[rd_idx];
		rd_lvl = lvl_q[rd_idx];
	end

	always_comb begin
		tt = (it_q > {1'b0, il_q}) ? il_q : it_q[TW-1:0];
		mag = (ib_q >= ia_q) ? TW'(ib_q - ia_q) : TW'(ia_q - ib_q);
		mul_a = '0;
		mul_b = '0;
		case (op)
			avb_pkg::DP_IMUL: begin
				mul_a = mag;
				mul_b = tt;
			end
			avb_pkg::DP_GM: begin
				mul_a = TW'(rd_gain);
				mul_b = TW'(cfg.master);
			end
			avb_pkg::DP_LO: begin
				mul_a = TW'(gm_q[LW-1:0]);
				mul_b = TW'(env_q);
			end
			avb_pkg::DP_HI: begin
				mul_a = TW'(gm_q[2*LW-1:LW]);
				mul_b = TW'(env_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	always_comb begin
		trial = {rem_q, lowq_q[LW-1]};
		ge = trial >= {1'b0, il_q};
	end

	always_comb begin
		tgt_hi = acc_q[3*LW-1:2*LW-2];
		tgt = (tgt_hi > (LW+2)'(avb_pkg::LEVEL_MAX)) ? avb_pkg::LEVEL_MAX : tgt_hi[LW-1:0];
		lim = (cfg.max_step == '0) ? LW'(1) : cfg.max_step;
		if (tgt > rd_lvl) begin
			new_lvl = (LW'(tgt - rd_lvl) > lim) ? LW'(rd_lvl + lim) : tgt;
		end else begin
			new_lvl = (LW'(rd_lvl - tgt) > lim) ? LW'(rd_lvl - lim) : tgt;
		end
	end

	assign sel_bad = {28'd0, sel_q} >= 32'(VOICES);

	always_comb begin
		status.scan_done = !rd_en || (scan_q == VIW'(VOICES - 1));
		status.div_done = dcnt_q == 5'(LW - 1);
		status.enabled = rd_en;
		status.held = rd_held;
	end

	// flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0;
			held_q <= '0;
		end else begin
			case (op)
				avb_pkg::DP_EXEC: begin
					case (cmd_q)
						avb_pkg::CMD_PRESS_ALLOC, avb_pkg::CMD_PRESS_VOICE: begin
							en_q[v_q] <= 1'b1;
							held_q[v_q] <= 1'b1;
						end
						avb_pkg::CMD_RELEASE: held_q[v_q] <= 1'b0;
						avb_pkg::CMD_RELEASE_ALL: held_q <= '0;
						default: ;
					endcase
				end
				avb_pkg::DP_TICK: begin
					if (rd_en && !rd_held && rd_rc == TW'(1)) begin
						en_q[v_q] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// voice payload and working registers
	always_ff @(posedge clk) begin
		case (op)
			avb_pkg::DP_LATCH: begin
				cmd_q <= command;
				sel_q <= voice_sel;
				lvlin_q <= voice_level;
				v_q <= (command == avb_pkg::CMD_PRESS_ALLOC) ? VIW'(VOICES - 1) : VIW'(voice_sel);
				scan_q <= '0;
				best_q <= '1;
			end
			avb_pkg::DP_SCAN: begin
				if (!rd_en) begin
					v_q <= scan_q;
				end else if ({1'b0, rd_rc} < best_q) begin
					best_q <= {1'b0, rd_rc};
					v_q <= scan_q;
				end
				scan_q <= VIW'(scan_q + 1'b1);
			end
			avb_pkg::DP_EXEC: begin
				case (cmd_q)
					avb_pkg::CMD_PRESS_ALLOC, avb_pkg::CMD_PRESS_VOICE: begin
						pc_q[v_q] <= PW'(cfg.attack) + PW'(cfg.decay);
						rc_q[v_q] <= cfg.release_len;
						gain_q[v_q] <= lvlin_q;
						lvl_q[v_q] <= '0;
					end
					avb_pkg::CMD_SET_LEVEL: gain_q[v_q] <= lvlin_q;
					default: ;
				endcase
			end
			avb_pkg::DP_TICK: begin
				if (rd_en) begin
					if (rd_held) begin
						if (rd_pc != '0) pc_q[v_q] <= PW'(rd_pc - 1'b1);
					end else if (rd_rc != '0) begin
						rc_q[v_q] <= TW'(rd_rc - 1'b1);
						if (rd_rc == TW'(1)) lvl_q[v_q] <= '0;
					end
				end
			end
			avb_pkg::DP_ENV_SET: begin
				if (rd_pc > {1'b0, cfg.decay}) begin
					ia_q <= cfg.peak;
					ib_q <= '0;
					it_q <= PW'(rd_pc - {1'b0, cfg.decay});
					il_q <= cfg.attack;
				end else if (rd_pc != '0) begin
					ia_q <= cfg.sustain;
					ib_q <= cfg.peak;
					it_q <= rd_pc;
					il_q <= cfg.decay;
				end else begin
					ia_q <= cfg.sustain;
					ib_q <= '0;
					it_q <= '0;
					il_q <= '0;
				end
			end
			avb_pkg::DP_REL_SET: begin
				ia_q <= '0;
				ib_q <= env_q;
				it_q <= {1'b0, rd_rc};
				il_q <= cfg.release_len;
			end
			avb_pkg::DP_IMUL: begin
				rem_q <= mul_p[TW+LW-1:LW];
				lowq_q <= mul_p[LW-1:0];
				dcnt_q <= '0;
				neg_q <= ib_q < ia_q;
				zero_q <= il_q == '0;
			end
			avb_pkg::DP_IDIV: begin
				rem_q <= ge ? TW'(trial - {1'b0, il_q}) : trial[TW-1:0];
				lowq_q <= {lowq_q[LW-2:0], ge};
				dcnt_q <= 5'(dcnt_q + 1'b1);
			end
			avb_pkg::DP_IFIN: begin
				if (zero_q) env_q <= ia_q;
				else if (neg_q) env_q <= LW'(ia_q - lowq_q);
				else env_q <= LW'(ia_q + lowq_q);
			end
			avb_pkg::DP_GM: gm_q <= mul_p[2*LW-1:0];
			avb_pkg::DP_LO: acc_q <= (3*LW)'(mul_p[2*LW-1:0]);
			avb_pkg::DP_HI: hi_q <= mul_p[2*LW-1:0];
			avb_pkg::DP_SUM: acc_q <= acc_q + {hi_q, {LW{1'b0}}};
			avb_pkg::DP_SLEW: lvl_q[v_q] <= new_lvl;
			avb_pkg::DP_OUT: begin
				case (cmd_q)
					avb_pkg::CMD_STEP, avb_pkg::CMD_PRESS_VOICE, avb_pkg::CMD_RELEASE,
					avb_pkg::CMD_SET_LEVEL: begin
						voice_out <= sel_bad ? sel_q : avb_pkg::SEL_W'(v_q);
						level_out <= (!sel_bad && rd_en) ? rd_lvl : '0;
						active <= !sel_bad && rd_en;
					end
					avb_pkg::CMD_PRESS_ALLOC: begin
						voice_out <= avb_pkg::SEL_W'(v_q);
						level_out <= rd_en ? rd_lvl : '0;
						active <= rd_en;
					end
					default: begin
						voice_out <= '0;
						level_out <= '0;
						active <= 1'b0;
					end
				endcase
			end
			default: ;
		endcase
	end

endmodule

### hw/rtl/avb_ctrl.sv
// command sequencer and output word handshake
`timescale 1ns / 1ps
module avb_ctrl #(
	parameter int VOICES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [avb_pkg::CMD_W-1:0]     command,
	input  logic [avb_pkg::SEL_W-1:0]     voice_sel,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  avb_pkg::dp_status_t           status,
	output avb_pkg::dp_op_t               op
);
	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_EXEC, S_TICK, S_ENV, S_IMUL, S_IDIV, S_IFIN, S_RELSET,
		S_GM, S_LO, S_HI, S_SUM, S_SLEW, S_OUT
	} state_t;

	state_t state_q;
	logic rel_q, out_valid_q;
	logic in_fire, sel_bad, load;

	assign in_ready = state_q == S_IDLE;
	assign in_fire = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign sel_bad = {28'd0, voice_sel} >= 32'(VOICES);
	assign load = state_q == S_OUT && (!out_valid_q || out_ready);

	always_comb begin
		case (state_q)
			S_IDLE: op = in_fire ? avb_pkg::DP_LATCH : avb_pkg::DP_NOP;
			S_SCAN: op = avb_pkg::DP_SCAN;
			S_EXEC: op = avb_pkg::DP_EXEC;
			S_TICK: op = avb_pkg::DP_TICK;
			S_ENV: op = status.enabled ? avb_pkg::DP_ENV_SET : avb_pkg::DP_NOP;
			S_IMUL: op = avb_pkg::DP_IMUL;
			S_IDIV: op = avb_pkg::DP_IDIV;
			S_IFIN: op = avb_pkg::DP_IFIN;
			S_RELSET: op = avb_pkg::DP_REL_SET;
			S_GM: op = avb_pkg::DP_GM;
			S_LO: op = avb_pkg::DP_LO;
			S_HI: op = avb_pkg::DP_HI;
			S_SUM: op = avb_pkg::DP_SUM;
			S_SLEW: op = avb_pkg::DP_SLEW;
			S_OUT: op = load ? avb_pkg::DP_OUT : avb_pkg::DP_NOP;
			default: op = avb_pkg::DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rel_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (command == avb_pkg::CMD_PRESS_ALLOC) begin
							state_q <= S_SCAN;
						end else if (command == avb_pkg::CMD_RELEASE_ALL) begin
							state_q <= S_EXEC;
						end else if (command inside {avb_pkg::CMD_STEP,
								avb_pkg::CMD_PRESS_VOICE, avb_pkg::CMD_RELEASE,
								avb_pkg::CMD_SET_LEVEL} && !sel_bad) begin
							state_q <= (command == avb_pkg::CMD_STEP) ? S_TICK : S_EXEC;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SCAN: if (status.scan_done) state_q <= S_EXEC;
				S_EXEC: state_q <= S_OUT;
				S_TICK: begin
					rel_q <= 1'b0;
					state_q <= S_ENV;
				end
				S_ENV: state_q <= status.enabled ? S_IMUL : S_OUT;
				S_IMUL: state_q <= S_IDIV;
				S_IDIV: if (status.div_done) state_q <= S_IFIN;
				S_IFIN: state_q <= (!rel_q && !status.held) ? S_RELSET : S_GM;
				S_RELSET: begin
					rel_q <= 1'b1;
					state_q <= S_IMUL;
				end
				S_GM: state_q <= S_LO;
				S_LO: state_q <= S_HI;
				S_HI: state_q <= S_SUM;
				S_SUM: state_q <= S_SLEW;
				S_SLEW: state_q <= S_OUT;
				S_OUT: if (load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("accepted word did not start a sequence");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid_q)
		else $error("result load lost");

	a_scan_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && status.scan_done) |=> state_q == S_EXEC)
		else $error("allocation scan did not finish into press");

	a_release_once: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RELSET |=> rel_q)
		else $error("release pass flag not set");

endmodule

### tb/adsr_voice_bank_tb.sv
// self-checking testbench for the envelope voice bank: command stream, predictor and checker
`timescale 1ns / 1ps
module adsr_voice_bank_tb;

	localparam int NV = 16;
	localparam logic [avb_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
	localparam logic [avb_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;
	localparam longint unsigned GAIN_DIV = 64'd1 << 40;

	typedef struct packed {
		logic [avb_pkg::CMD_W-1:0] cmd;
		logic [avb_pkg::SEL_W-1:0] sel;
		logic [avb_pkg::LEVEL_W-1:0] lvl;
	} cmd_word_t;

	typedef struct packed {
		logic [avb_pkg::SEL_W-1:0] voice;
		logic [avb_pkg::LEVEL_W-1:0] level;
		logic act;
	} voice_res_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [avb_pkg::CMD_W-1:0] command;
	logic [avb_pkg::SEL_W-1:0] voice_sel, voice_out;
	logic [avb_pkg::LEVEL_W-1:0] voice_level, level_out;
	logic active;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	adsr_voice_bank u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .voice_sel(voice_sel), .voice_level(voice_level),
		.out_valid(out_valid), .out_ready(out_ready),
		.voice_out(voice_out), .level_out(level_out), .active(active),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cmd_word_t pending_cmds[$];
	voice_res_t expected_res[$];
	int errors = 0;
	bit idle_on = 1'b0;

	avb_pkg::cfg_t env_cfg;
	logic en_f[NV];
	logic held_f[NV];
	logic [avb_pkg::PRESS_W-1:0] press_cnt[NV];
	logic [avb_pkg::TIMER_W-1:0] rel_cnt[NV];
	logic [avb_pkg::LEVEL_W-1:0] gain_r[NV];
	logic [avb_pkg::LEVEL_W-1:0] cur_lvl[NV];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic longint lerp(longint a, longint b, longint t, longint len);
		if (len == 0) return a;
		if (t > len) t = len;
		return a + ((b - a) * t) / len;
	endfunction

	function automatic void move_level(int v);
		longint pc, att_t, env, tgt, cur, d, lim;
		longint unsigned prod;
		if (!en_f[v]) begin
			cur_lvl[v] = '0;
			return;
		end
		pc = longint'(press_cnt[v]);
		att_t = pc - longint'(env_cfg.decay);
		if (att_t > 0)
			env = lerp(longint'(env_cfg.peak), 0, att_t, longint'(env_cfg.attack));
		else if (pc > 0)
			env = lerp(longint'(env_cfg.sustain), longint'(env_cfg.peak), pc,
				longint'(env_cfg.decay));
		else
			env = longint'(env_cfg.sustain);
		if (!held_f[v])
			env = lerp(0, env, longint'(rel_cnt[v]), longint'(env_cfg.release_len));
		prod = longint'(gain_r[v]) * longint'(env_cfg.master);
		prod = prod * longint'(env) / GAIN_DIV;
		if (prod > longint'(avb_pkg::LEVEL_MAX)) prod = longint'(avb_pkg::LEVEL_MAX);
		tgt = longint'(prod);
		cur = longint'(cur_lvl[v]);
		lim = (env_cfg.max_step == 0) ? 1 : longint'(env_cfg.max_step);
		d = tgt - cur;
		if (d < -lim) d = -lim;
		if (d > lim) d = lim;
		cur_lvl[v] = avb_pkg::LEVEL_W'(cur + d);
	endfunction

	function automatic void start_voice(int v, logic [avb_pkg::LEVEL_W-1:0] g);
		en_f[v] = 1'b1;
		held_f[v] = 1'b1;
		press_cnt[v] = avb_pkg::PRESS_W'(env_cfg.attack) + avb_pkg::PRESS_W'(env_cfg.decay);
		rel_cnt[v] = env_cfg.release_len;
		gain_r[v] = g;
		cur_lvl[v] = '0;
	endfunction

	function automatic voice_res_t apply_cmd(cmd_word_t w);
		voice_res_t r;
		int v;
		logic [avb_pkg::TIMER_W:0] best;
		r = '0;
		v = int'(w.sel);
		case (w.cmd)
			avb_pkg::CMD_PRESS_ALLOC: begin
				best = '1;
				v = NV - 1;
				for (int i = 0; i < NV; i++) begin
					if (!en_f[i]) begin
						v = i;
						break;
					end
					if ({1'b0, rel_cnt[i]} < best) begin
						best = {1'b0, rel_cnt[i]};
						v = i;
					end
				end
				start_voice(v, w.lvl);
			end
			avb_pkg::CMD_RELEASE_ALL: begin
				for (int i = 0; i < NV; i++) held_f[i] = 1'b0;
				return r;
			end
			avb_pkg::CMD_STEP: begin
				if (en_f[v]) begin
					if (held_f[v]) begin
						if (press_cnt[v] != 0) press_cnt[v]--;
					end else if (rel_cnt[v] != 0) begin
						rel_cnt[v]--;
						if (rel_cnt[v] == 0) en_f[v] = 1'b0;
					end
					move_level(v);
				end
			end
			avb_pkg::CMD_PRESS_VOICE: start_voice(v, w.lvl);
			avb_pkg::CMD_RELEASE: held_f[v] = 1'b0;
			avb_pkg::CMD_SET_LEVEL: gain_r[v] = w.lvl;
			default: return r;
		endcase
		r.voice = avb_pkg::SEL_W'(v);
		r.level = cur_lvl[v];
		r.act = en_f[v];
		return r;
	endfunction

	// handshake sampling, prediction and checking
	logic in_acc, out_acc;
	always @(posedge clk) begin
		voice_res_t e;
		in_acc <= in_valid && in_ready;
		out_acc <= out_valid && out_ready;
		if (arst_n && in_valid && in_ready)
			expected_res.push_back(apply_cmd('{command, voice_sel, voice_level}));
		if (arst_n && out_valid && out_ready) begin
			if (expected_res.size() == 0) begin
				report("unexpected word", voice_out, 0);
			end else begin
				e = expected_res.pop_front();
				if (voice_out !== e.voice) report("voice_out", voice_out, e.voice);
				if (level_out !== e.level) report("level_out", level_out, e.level);
				if (active !== e.act) report("active", active, e.act);
			end
		end
	end

	function automatic int draw_gap();
		if (!idle_on) return 0;
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
	endfunction

	// input driver
	int in_gap = 0;
	always @(negedge clk) begin
		cmd_word_t w;
		if (arst_n) begin
			if (in_valid && !in_acc) begin
			end else begin
				if (in_valid) in_gap = draw_gap();
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (pending_cmds.size() > 0) begin
					w = pending_cmds.pop_front();
					command <= w.cmd;
					voice_sel <= w.sel;
					voice_level <= w.lvl;
					in_valid <= 1'b1;
					if (idle_on) in_gap = 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output stall
	int out_stall = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_acc) out_stall = draw_gap();
			if (out_stall > 0) begin
				out_ready <= 1'b0;
				out_stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		logic [31:0] want;
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = {idx, 2'b00}; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			avb_pkg::REG_ATTACK: env_cfg.attack = val[avb_pkg::TIMER_W-1:0];
			avb_pkg::REG_DECAY: env_cfg.decay = val[avb_pkg::TIMER_W-1:0];
			avb_pkg::REG_RELEASE: env_cfg.release_len = val[avb_pkg::TIMER_W-1:0];
			avb_pkg::REG_PEAK: env_cfg.peak = val[avb_pkg::LEVEL_W-1:0];
			avb_pkg::REG_SUSTAIN: env_cfg.sustain = val[avb_pkg::LEVEL_W-1:0];
			avb_pkg::REG_MASTER: env_cfg.master = val[avb_pkg::LEVEL_W-1:0];
			default: env_cfg.max_step = val[avb_pkg::LEVEL_W-1:0];
		endcase
		want = (idx <= avb_pkg::REG_RELEASE) ? 32'(val[avb_pkg::TIMER_W-1:0]) :
			32'(val[avb_pkg::LEVEL_W-1:0]);
		@(negedge clk);
		psel = 1'b1; paddr = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata !== want) report("prdata", prdata, want);
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
	endtask

	task automatic set_env(input logic [31:0] att, dec, rel, pk, sus, mst, stp);
		reg_write(avb_pkg::REG_ATTACK, att);
		reg_write(avb_pkg::REG_DECAY, dec);
		reg_write(avb_pkg::REG_RELEASE, rel);
		reg_write(avb_pkg::REG_PEAK, pk);
		reg_write(avb_pkg::REG_SUSTAIN, sus);
		reg_write(avb_pkg::REG_MASTER, mst);
		reg_write(avb_pkg::REG_MAX_STEP, stp);
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || in_valid || expected_res.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [avb_pkg::LEVEL_W-1:0] pick_level();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return avb_pkg::LEVEL_W'(1 << 20);
			2: return avb_pkg::LEVEL_MAX;
			default: return avb_pkg::LEVEL_W'($urandom);
		endcase
	endfunction

	function automatic void push(logic [avb_pkg::CMD_W-1:0] c, int s,
			logic [avb_pkg::LEVEL_W-1:0] l);
		pending_cmds.push_back('{c, avb_pkg::SEL_W'(s), l});
	endfunction

	// press, hold, release and decay random voices, with set-level, release-all, spare words and allocate bursts mixed in
	function automatic void gen_random(int n);
		int v, k, cnt;
		cnt = 0;
		while (cnt < n) begin
			v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NV - 1) : $urandom_range(0, 3);
			case ($urandom_range(0, 9))
				0: begin
					push(avb_pkg::CMD_SET_LEVEL, v, pick_level());
					push(avb_pkg::CMD_RELEASE_ALL, $urandom_range(0, 15),
						avb_pkg::LEVEL_W'($urandom));
					cnt += 2;
				end
				1: begin
					push($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B,
						$urandom_range(0, 15), avb_pkg::LEVEL_W'($urandom));
					k = $urandom_range(1, 18);
					for (int i = 0; i < k; i++) push(avb_pkg::CMD_PRESS_ALLOC, 0, pick_level());
					cnt += k + 1;
				end
				default: begin
					if ($urandom_range(0, 1)) push(avb_pkg::CMD_PRESS_VOICE, v, pick_level());
					else push(avb_pkg::CMD_PRESS_ALLOC, $urandom_range(0, 15), pick_level());
					k = $urandom_range(0, 30);
					for (int i = 0; i < k; i++) push(avb_pkg::CMD_STEP, v, avb_pkg::LEVEL_W'($urandom));
					cnt += k + 2;
					push(avb_pkg::CMD_RELEASE, v, avb_pkg::LEVEL_W'($urandom));
					k = $urandom_range(0, 40);
					for (int i = 0; i < k; i++) push(avb_pkg::CMD_STEP, v, avb_pkg::LEVEL_W'($urandom));
					cnt += k;
				end
			endcase
		end
	endfunction

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; out_ready = 1'b0;
		command = '0; voice_sel = '0; voice_level = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		env_cfg = '{attack: 3360, decay: 9600, release_len: 2400, peak: 1048576,
			sustain: 524288, master: 524288, max_step: 699};
		for (int i = 0; i < NV; i++) begin
			en_f[i] = 0; held_f[i] = 0; press_cnt[i] = 0;
			rel_cnt[i] = 0; gain_r[i] = 0; cur_lvl[i] = 0;
		end
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words under reset defaults
		push(avb_pkg::CMD_STEP, 5, avb_pkg::LEVEL_MAX);
		push(avb_pkg::CMD_PRESS_VOICE, 0, avb_pkg::LEVEL_MAX);
		push(avb_pkg::CMD_STEP, 0, 0);
		push(avb_pkg::CMD_STEP, 0, 0);
		push(avb_pkg::CMD_PRESS_ALLOC, 15, 0);
		push(avb_pkg::CMD_PRESS_ALLOC, 0, avb_pkg::LEVEL_W'(1 << 20));
		push(avb_pkg::CMD_SET_LEVEL, 15, avb_pkg::LEVEL_MAX);
		push(avb_pkg::CMD_PRESS_VOICE, 15, avb_pkg::LEVEL_W'(1 << 20));
		push(avb_pkg::CMD_STEP, 15, 0);
		push(avb_pkg::CMD_RELEASE, 0, 0);
		push(avb_pkg::CMD_STEP, 0, 0);
		push(avb_pkg::CMD_RELEASE_ALL, 15, avb_pkg::LEVEL_MAX);
		push(avb_pkg::CMD_STEP, 15, 0);
		push(CMD_SPARE_A, 15, avb_pkg::LEVEL_MAX);
		push(CMD_SPARE_B, 7, 0);
		push(avb_pkg::CMD_SET_LEVEL, 1, 0);
		push(avb_pkg::CMD_STEP, 1, 0);
		push(avb_pkg::CMD_PRESS_ALLOC, 10, 21'h0aaaaa);
		push(avb_pkg::CMD_PRESS_ALLOC, 5, 21'h155555);
		drain();

		// zero lengths, zero slew, zero release
		idle_on = 1'b1;
		set_env(32'hff000000, 0, 0, 32'hffe00000, 0, 0, 0);
		push(avb_pkg::CMD_PRESS_VOICE, 2, avb_pkg::LEVEL_MAX);
		push(avb_pkg::CMD_RELEASE, 2, 0);
		push(avb_pkg::CMD_STEP, 2, 0);
		gen_random(200);
		drain();

		// short envelope, full scale, fast slew
		set_env(5, 7, 3, 1 << 20, 1 << 19, 1 << 20, 1 << 20);
		gen_random(300);
		drain();

		idle_on = 1'b0;
		set_env(2, 0, 20, avb_pkg::LEVEL_MAX, avb_pkg::LEVEL_MAX, avb_pkg::LEVEL_MAX, 4000);
		gen_random(250);
		drain();

		// extremes
		idle_on = 1'b1;
		set_env(32'hffffffff, 32'h00ffffff, 32'h00ffffff, avb_pkg::LEVEL_MAX, 0,
			avb_pkg::LEVEL_MAX, avb_pkg::LEVEL_MAX);
		gen_random(250);
		drain();

		for (int ph = 0; ph < 2; ph++) begin
			set_env($urandom_range(0, 25), $urandom_range(0, 25), $urandom_range(1, 30),
				$urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
				$urandom_range(0, 1 << 20), $urandom_range(1, 200000));
			gen_random(250);
			drain();
		end

		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/avb_pkg.sv
hw/rtl/avb_dp.sv
hw/rtl/avb_ctrl.sv
hw/rtl/adsr_voice_bank.sv
tb/adsr_voice_bank_tb.sv
